// File: rtl/core/assert_macros.svh
// Assertion macros shared by the escaper RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implication");
// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: rtl/core/sqe_pkg.sv
// Package with the character constants, descriptor type and helpers of the escaper.
`default_nettype none
package sqe_pkg;

    localparam int MAX_CHARS  = 6;
    localparam int CNT_W      = $clog2(MAX_CHARS + 1);
    localparam int IDX_W      = $clog2(MAX_CHARS);
    localparam int FIFO_DEPTH = 2;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int FILL_W     = $clog2(FIFO_DEPTH + 1);

    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_RETURN    = 8'h0D;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_LOWER_N   = 8'h6E;
    localparam logic [7:0] CH_LOWER_R   = 8'h72;
    localparam logic [7:0] CH_LOWER_T   = 8'h74;
    localparam logic [7:0] CH_LOWER_X   = 8'h78;
    localparam logic [7:0] CH_PRINT_LO  = 8'h20;
    localparam logic [7:0] CH_PRINT_HI  = 8'h7E;

    // One queued transaction: the characters it emits, in order, and how many.
    typedef struct packed {
        logic [MAX_CHARS-1:0][7:0] chars;
        logic [CNT_W-1:0]          char_count;
        logic                      closes;
    } sqe_desc_t;

    // Lower-case hex digit for one nibble.
    function automatic logic [7:0] hex_digit(input logic [3:0] nib);
        logic [7:0] res;
        if (nib < 4'd10) begin
            res = 8'h30 + {4'd0, nib};
        end
        else begin
            res = 8'h57 + {4'd0, nib};
        end
        return res;
    endfunction

endpackage
`default_nettype wire

// File: rtl/core/sqe_front.sv
// Front end: classifies one input byte into the character sequence it produces.
`default_nettype none
module sqe_front
    import sqe_pkg::*;
(
    input  wire logic [7:0] data_byte,
    input  wire logic       starts_string,
    input  wire logic       ends_string,
    input  wire logic       empty_string,
    output sqe_desc_t       desc
);

    logic [3:0][7:0]  body;
    logic [CNT_W-1:0] body_len;
    logic [IDX_W-1:0] close_idx;

    // Escape sequence of the byte itself, one to four characters.
    always_comb
    begin
        body     = '0;
        body_len = CNT_W'(1);
        if (data_byte == CH_BACKSLASH) begin
            body[0]  = CH_BACKSLASH;
            body[1]  = CH_BACKSLASH;
            body_len = CNT_W'(2);
        end
        else if (data_byte == CH_QUOTE) begin
            body[0]  = CH_BACKSLASH;
            body[1]  = CH_QUOTE;
            body_len = CNT_W'(2);
        end
        else if (data_byte == CH_NEWLINE) begin
            body[0]  = CH_BACKSLASH;
            body[1]  = CH_LOWER_N;
            body_len = CNT_W'(2);
        end
        else if (data_byte == CH_RETURN) begin
            body[0]  = CH_BACKSLASH;
            body[1]  = CH_LOWER_R;
            body_len = CNT_W'(2);
        end
        else if (data_byte == CH_TAB) begin
            body[0]  = CH_BACKSLASH;
            body[1]  = CH_LOWER_T;
            body_len = CNT_W'(2);
        end
        else if (data_byte < CH_PRINT_LO || data_byte > CH_PRINT_HI) begin
            body[0]  = CH_BACKSLASH;
            body[1]  = CH_LOWER_X;
            body[2]  = hex_digit(data_byte[7:4]);
            body[3]  = hex_digit(data_byte[3:0]);
            body_len = CNT_W'(4);
        end
        else begin
            body[0] = data_byte;
        end
    end

    // Framing: opening quote in front, closing quote after the body.
    always_comb
    begin
        desc      = '0;
        close_idx = IDX_W'({2'd0, starts_string} + body_len);
        if (empty_string) begin
            desc.chars[0]   = CH_QUOTE;
            desc.chars[1]   = CH_QUOTE;
            desc.char_count = CNT_W'(2);
            desc.closes     = 1'b1;
        end
        else begin
            if (starts_string) begin
                desc.chars[0] = CH_QUOTE;
                desc.chars[1] = body[0];
                desc.chars[2] = body[1];
                desc.chars[3] = body[2];
                desc.chars[4] = body[3];
            end
            else begin
                desc.chars[0] = body[0];
                desc.chars[1] = body[1];
                desc.chars[2] = body[2];
                desc.chars[3] = body[3];
            end
            if (ends_string) begin
                desc.chars[close_idx] = CH_QUOTE;
            end
            desc.char_count = CNT_W'({2'd0, starts_string} + body_len + {2'd0, ends_string});
            desc.closes     = ends_string;
        end
    end

endmodule
`default_nettype wire

// File: rtl/core/sqe_fifo.sv
// Two-entry queue of character descriptors between the front and back ends.
`default_nettype none
`include "assert_macros.svh"
module sqe_fifo
    import sqe_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    input  wire sqe_desc_t push_desc,
    input  wire logic      pop,
    output logic           full,
    output logic           empty,
    output sqe_desc_t      head
);

    sqe_desc_t         mem_reg [FIFO_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [FILL_W-1:0] fill_reg, fill_next;

    assign full  = (fill_reg == FILL_W'(FIFO_DEPTH));
    assign empty = (fill_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        fill_next   = fill_reg + FILL_W'(push) - FILL_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Storage array, written at the write pointer.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_desc;
        end
    end

    `ASSERT_IMPLY(a_no_push_full, clk, rst_n, push, !full)
    `ASSERT_IMPLY(a_no_pop_empty, clk, rst_n, pop, !empty)
    `ASSERT_NEXT(a_fill_grows, clk, rst_n, push && !pop, fill_reg == $past(fill_reg) + FILL_W'(1))

endmodule
`default_nettype wire

// File: rtl/core/sqe_back.sv
// Back end: sequences the queued characters onto the result port, one per cycle.
`default_nettype none
`include "assert_macros.svh"
module sqe_back
    import sqe_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       empty,
    input  wire sqe_desc_t  head,
    output logic            pop,
    output logic            valid,
    output logic [7:0]      out_char,
    output logic            run_last,
    output logic            string_done
);

    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             valid_reg, valid_next;
    logic [7:0]       char_reg, char_next;
    logic             last_reg, last_next;
    logic             done_reg, done_next;
    logic             at_last;

    // Walk through the head descriptor; pop it with its final character.
    always_comb
    begin
        at_last    = (idx_reg == IDX_W'(head.char_count - CNT_W'(1)));
        pop        = !empty && at_last;
        valid_next = !empty;
        char_next  = head.chars[idx_reg];
        last_next  = at_last;
        done_next  = at_last && head.closes;
        if (empty)
        begin
            idx_next = idx_reg;
        end
        else if (at_last)
        begin
            idx_next = '0;
        end
        else
        begin
            idx_next = idx_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    // Result payload registers.
    always_ff @(posedge clk)
    begin
        char_reg <= char_next;
        last_reg <= last_next;
        done_reg <= done_next;
    end

    assign valid       = valid_reg;
    assign out_char    = char_reg;
    assign run_last    = valid_reg && last_reg;
    assign string_done = valid_reg && done_reg;

    `ASSERT_IMPLY(a_done_is_last, clk, rst_n, string_done, run_last && out_char == CH_QUOTE)
    `ASSERT_NEXT(a_run_continues, clk, rst_n, valid && !run_last, valid)
    `ASSERT_IMPLY(a_idx_idle, clk, rst_n, empty, idx_reg == '0)

endmodule
`default_nettype wire

// File: rtl/core/string_escape_quote_encoder.sv
// Top level of the quoted string escaper.
//
// Usage: one raw string byte is offered per transaction on data_byte with
// starts_string, ends_string and empty_string; it is taken at a rising edge
// where start is high and busy is low. The block emits the quoted, escaped
// text one character per cycle on out_char, marked by valid; run_last flags
// the final character of each transaction and string_done the closing quote.
// A front end classifies each byte into its character sequence (one to six
// characters), a two-entry queue holds these, and a back-end sequencer
// drives one character per cycle through registered outputs.
// An accepted byte is written into the queue storage, and its first character
// then leaves through the back end's output registers. Throughput: one output
// character per cycle; a transaction yields 1 to 6 characters (plain bytes 1,
// escapes 2 or 4, plus one per quote); the single-character output port sets this.
// busy is high while the queue holds two transactions.
// Reset clears the queue and the sequencer; no output strobes until input.
// The receiver cannot stall: every strobed character is taken at once.
`default_nettype none
module string_escape_quote_encoder
    import sqe_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    output logic            busy,
    input  wire logic [7:0] data_byte,
    input  wire logic       starts_string,
    input  wire logic       ends_string,
    input  wire logic       empty_string,
    output logic            valid,
    output logic [7:0]      out_char,
    output logic            run_last,
    output logic            string_done
);

    sqe_desc_t front_desc;
    sqe_desc_t head_desc;
    logic      push;
    logic      pop;
    logic      full;
    logic      empty;

    assign busy = full;
    assign push = start && !full;

    sqe_front u_front (
        .data_byte     (data_byte),
        .starts_string (starts_string),
        .ends_string   (ends_string),
        .empty_string  (empty_string),
        .desc          (front_desc)
    );

    sqe_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_desc (front_desc),
        .pop       (pop),
        .full      (full),
        .empty     (empty),
        .head      (head_desc)
    );

    sqe_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .empty       (empty),
        .head        (head_desc),
        .pop         (pop),
        .valid       (valid),
        .out_char    (out_char),
        .run_last    (run_last),
        .string_done (string_done)
    );

endmodule
`default_nettype wire

// File: dv/string_escape_quote_encoder_checker.sv
// Checker that predicts the quoted, escaped character stream and compares it with the block.
`timescale 1ns / 1ps
module string_escape_quote_encoder_checker
    import sqe_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    input  wire logic       busy,
    input  wire logic [7:0] data_byte,
    input  wire logic       starts_string,
    input  wire logic       ends_string,
    input  wire logic       empty_string,
    input  wire logic       valid,
    input  wire logic [7:0] out_char,
    input  wire logic       run_last,
    input  wire logic       string_done,
    output int              mismatch_count,
    output int              chars_pending
);

    localparam logic [7:0] CH_DIGIT_ZERO = 8'h30;
    localparam logic [7:0] CH_LOWER_A    = 8'h61;

    // One character of the escaped text with its two markers.
    typedef struct packed {
        logic [7:0] ch;
        logic       run_last;
        logic       string_done;
    } quoted_char_t;

    quoted_char_t expected_chars[$];
    int           error_total = 0;

    function automatic logic [7:0] nibble_to_hex(input logic [3:0] nib);
        logic [7:0] wide;
        wide = {4'd0, nib};
        return (nib > 4'd9) ? (CH_LOWER_A + wide - 8'd10) : (CH_DIGIT_ZERO + wide);
    endfunction

    // Work out every character that one transaction produces and queue them in order.
    function automatic void predict_escape(input logic [7:0] b, input logic is_first,
                                           input logic is_last, input logic is_empty);
        logic [7:0]   seq [0:5];
        logic [7:0]   letter;
        logic         closes;
        int           n;
        quoted_char_t item;
        n = 0;
        letter = 8'h00;
        closes = is_empty || is_last;
        if (is_empty)
        begin
            seq[0] = CH_QUOTE;
            seq[1] = CH_QUOTE;
            n = 2;
        end
        else
        begin
            if (is_first)
            begin
                seq[n] = CH_QUOTE;
                n = n + 1;
            end
            // Two-character escapes get a backslash and a letter or the byte itself.
            case (b)
                CH_BACKSLASH: letter = CH_BACKSLASH;
                CH_QUOTE:     letter = CH_QUOTE;
                CH_NEWLINE:   letter = CH_LOWER_N;
                CH_RETURN:    letter = CH_LOWER_R;
                CH_TAB:       letter = CH_LOWER_T;
                default:      letter = 8'h00;
            endcase
            if (letter != 8'h00)
            begin
                seq[n]     = CH_BACKSLASH;
                seq[n + 1] = letter;
                n = n + 2;
            end
            else if (b < CH_PRINT_LO || b > CH_PRINT_HI)
            begin
                seq[n]     = CH_BACKSLASH;
                seq[n + 1] = CH_LOWER_X;
                seq[n + 2] = nibble_to_hex(b[7:4]);
                seq[n + 3] = nibble_to_hex(b[3:0]);
                n = n + 4;
            end
            else
            begin
                seq[n] = b;
                n = n + 1;
            end
            if (is_last)
            begin
                seq[n] = CH_QUOTE;
                n = n + 1;
            end
        end
        for (int i = 0; i < n; i++)
        begin
            item.ch          = seq[i];
            item.run_last    = (i == n - 1);
            item.string_done = (i == n - 1) && closes;
            expected_chars   = {expected_chars, item};
        end
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t ns: %s", $time, msg);
        error_total = error_total + 1;
    endtask

    // Predict on every accepted transaction, then check any strobed character.
    always @(posedge clk)
    begin
        quoted_char_t want;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                predict_escape(data_byte, starts_string, ends_string, empty_string);
            end
            if (valid)
            begin
                if (expected_chars.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected character 0x%02h", out_char));
                end
                else
                begin
                    want = expected_chars.pop_front();
                    if (out_char !== want.ch)
                        report_mismatch($sformatf("out_char 0x%02h, expected 0x%02h",
                                                  out_char, want.ch));
                    if (run_last !== want.run_last)
                        report_mismatch($sformatf("run_last %b, expected %b on char 0x%02h",
                                                  run_last, want.run_last, want.ch));
                    if (string_done !== want.string_done)
                        report_mismatch($sformatf("string_done %b, expected %b on char 0x%02h",
                                                  string_done, want.string_done, want.ch));
                end
            end
        end
        mismatch_count <= error_total;
        chars_pending  <= expected_chars.size();
    end

endmodule

// File: dv/string_escape_quote_encoder_tb.sv
// Testbench top: clock, reset, byte stimulus and the final verdict for the string escaper.
`timescale 1ns / 1ps
module string_escape_quote_encoder_tb
    import sqe_pkg::*;
();

    localparam int TARGET_ITEMS = 150;
    localparam int QUIET_TAIL   = 30;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 100000;

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    logic [7:0] data_byte;
    logic       starts_string;
    logic       ends_string;
    logic       empty_string;
    logic       valid;
    logic [7:0] out_char;
    logic       run_last;
    logic       string_done;
    int         mismatch_count;
    int         chars_pending;
    int         cycle_count = 0;
    int         items_sent = 0;

    string_escape_quote_encoder i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .data_byte     (data_byte),
        .starts_string (starts_string),
        .ends_string   (ends_string),
        .empty_string  (empty_string),
        .valid         (valid),
        .out_char      (out_char),
        .run_last      (run_last),
        .string_done   (string_done)
    );

    string_escape_quote_encoder_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .data_byte      (data_byte),
        .starts_string  (starts_string),
        .ends_string    (ends_string),
        .empty_string   (empty_string),
        .valid          (valid),
        .out_char       (out_char),
        .run_last       (run_last),
        .string_done    (string_done),
        .mismatch_count (mismatch_count),
        .chars_pending  (chars_pending)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // Hard stop in case the block hangs on busy or stops producing characters.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Offer one transaction after an optional idle gap and wait until it is taken.
    task automatic send_byte(input int gap, input logic [7:0] b, input logic is_first,
                             input logic is_last, input logic is_empty);
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start         <= 1'b1;
        data_byte     <= b;
        starts_string <= is_first;
        ends_string   <= is_last;
        empty_string  <= is_empty;
        @(posedge clk);
        while (busy) @(posedge clk);
        items_sent = items_sent + 1;
    endtask

    // Mix of byte classes so escapes, hex forms and plain text all appear often.
    function automatic logic [7:0] pick_string_byte();
        logic [7:0] b;
        case ($urandom_range(0, 5))
            0: b = 8'($urandom_range(0, 255));
            1, 2: b = 8'($urandom_range(32, 126));
            3: b = 8'($urandom_range(0, 31));
            4: b = 8'($urandom_range(128, 255));
            default:
            begin
                case ($urandom_range(0, 4))
                    0: b = CH_BACKSLASH;
                    1: b = CH_QUOTE;
                    2: b = CH_NEWLINE;
                    3: b = CH_RETURN;
                    default: b = CH_TAB;
                endcase
            end
        endcase
        return b;
    endfunction

    initial
    begin
        int str_len;
        int gap;
        bit idling;
        rst_n         <= 1'b0;
        start         <= 1'b0;
        data_byte     <= 8'h00;
        starts_string <= 1'b0;
        ends_string   <= 1'b0;
        empty_string  <= 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty strings with junk in the ignored fields, range edges, every escape.
        send_byte(0, 8'hFF, 1'b1, 1'b1, 1'b1);
        send_byte(0, 8'h00, 1'b0, 1'b0, 1'b1);
        send_byte(0, 8'h00, 1'b1, 1'b1, 1'b0);
        send_byte(2, 8'hFF, 1'b1, 1'b1, 1'b0);
        send_byte(0, CH_BACKSLASH, 1'b1, 1'b1, 1'b0);
        send_byte(0, CH_QUOTE, 1'b1, 1'b1, 1'b0);
        send_byte(1, CH_NEWLINE, 1'b1, 1'b0, 1'b0);
        send_byte(0, CH_RETURN, 1'b0, 1'b0, 1'b0);
        send_byte(0, CH_TAB, 1'b0, 1'b1, 1'b0);
        send_byte(3, 8'h1F, 1'b1, 1'b0, 1'b0);
        send_byte(0, 8'h20, 1'b0, 1'b0, 1'b0);
        send_byte(0, 8'h7E, 1'b0, 1'b0, 1'b0);
        send_byte(0, 8'h7F, 1'b0, 1'b0, 1'b0);
        send_byte(0, 8'h80, 1'b0, 1'b1, 1'b0);
        send_byte(0, 8'h41, 1'b1, 1'b1, 1'b0);
        // Framing that does not alternate properly is still taken item by item.
        send_byte(0, CH_BACKSLASH, 1'b0, 1'b0, 1'b0);
        send_byte(0, 8'h61, 1'b0, 1'b1, 1'b0);
        send_byte(0, 8'h61, 1'b0, 1'b1, 1'b0);
        send_byte(0, 8'h0B, 1'b1, 1'b0, 1'b0);
        send_byte(0, 8'h1A, 1'b1, 1'b0, 1'b0);
        send_byte(0, 8'h9C, 1'b0, 1'b1, 1'b0);

        // Random: mostly well-formed strings, some stray items with random flags.
        while (items_sent < TARGET_ITEMS)
        begin
            idling = (items_sent < TARGET_ITEMS - QUIET_TAIL) && ($urandom_range(0, 2) != 0);
            if ($urandom_range(0, 6) == 0)
            begin
                gap = idling ? $urandom_range(1, 19) : 0;
                send_byte(gap, pick_string_byte(), 1'($urandom), 1'($urandom),
                          ($urandom_range(0, 7) == 0));
            end
            else
            begin
                str_len = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 8);
                if (str_len == 0)
                begin
                    gap = (idling && $urandom_range(0, 2) == 0) ? $urandom_range(1, 19) : 0;
                    send_byte(gap, 8'($urandom), 1'($urandom), 1'($urandom), 1'b1);
                end
                for (int i = 0; i < str_len; i++)
                begin
                    gap = (idling && $urandom_range(0, 2) == 0) ? $urandom_range(1, 19) : 0;
                    send_byte(gap, pick_string_byte(), (i == 0), (i == str_len - 1), 1'b0);
                end
            end
        end
        start <= 1'b0;

        // Let every predicted character come out, then watch for strays.
        while (chars_pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
